[rtl/core/vsa_pkg.sv]
package vsa_pkg;

    // fixed field widths
    localparam int CMD_W  = 3;
    localparam int IDX_W  = 7;
    localparam int PRIO_W = 4;
    localparam int ENT_W  = 11;
    localparam int CHAN_W = 9;
    localparam int TIME_W = 32;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 8;

    // slots_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOCK     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNLOCK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP_ALL = 3'd4;

    // grant kinds
    localparam logic [KIND_W-1:0] KIND_MATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEAL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] last_use;
        logic [ENT_W-1:0]  entity;
        logic [CHAN_W-1:0] channel;
    } slot_data_t;

    typedef struct packed {
        logic       active;
        logic       locked;
        slot_data_t data;
    } slot_rec_t;

    // write-side operations on the slot store
    typedef struct packed {
        logic wr_en;
        logic kill_en;
        logic lk_en;
        logic lk_val;
    } store_op_t;

    // verdict of the compare unit on one slot
    typedef struct packed {
        logic is_empty;
        logic is_weaker;
        logic is_match;
    } cmp_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RELEASE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // contents of a killed slot
    localparam slot_data_t KILL_DATA = '{prio: '0, last_use: '0, entity: '1, channel: '1};

endpackage

[rtl/core/vsa_slot_store.sv]
module vsa_slot_store #(
    parameter int NUM_SLOTS = 128,
    parameter int SLOT_W    = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [SLOT_W-1:0]   rd_addr,
    input  logic [SLOT_W-1:0]   wr_addr,
    input  vsa_pkg::store_op_t  op,
    input  vsa_pkg::slot_data_t wr_data,
    output vsa_pkg::slot_rec_t  rd_rec
);

    vsa_pkg::slot_data_t data_mem [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] locked_reg;

    vsa_pkg::slot_data_t rd_data_reg;
    logic                rd_valid_reg;
    logic                rd_active_reg;
    logic                rd_locked_reg;

    logic kill_ok;

    // a kill leaves a locked slot alone
    assign kill_ok = op.kill_en && !locked_reg[wr_addr];

    // per-slot flags, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            active_reg <= '0;
            locked_reg <= '0;
        end else if (op.wr_en) begin
            valid_reg[wr_addr]  <= 1'b1;
            active_reg[wr_addr] <= 1'b1;
            locked_reg[wr_addr] <= 1'b0;
        end else if (kill_ok) begin
            valid_reg[wr_addr]  <= 1'b1;
            active_reg[wr_addr] <= 1'b0;
        end else if (op.lk_en) begin
            locked_reg[wr_addr] <= op.lk_val;
        end
    end

    // slot payload memory, one write port
    always_ff @(posedge aclk) begin
        if (op.wr_en) begin
            data_mem[wr_addr] <= wr_data;
        end else if (kill_ok) begin
            data_mem[wr_addr] <= vsa_pkg::KILL_DATA;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg   <= data_mem[rd_addr];
        rd_valid_reg  <= valid_reg[rd_addr];
        rd_active_reg <= active_reg[rd_addr];
        rd_locked_reg <= locked_reg[rd_addr];
    end

    // never-written slots read as zero data
    always_comb begin
        rd_rec.active = rd_active_reg;
        rd_rec.locked = rd_locked_reg;
        rd_rec.data   = rd_valid_reg ? rd_data_reg : '0;
    end

endmodule

[rtl/core/vsa_cmp_unit.sv]
module vsa_cmp_unit (
    input  vsa_pkg::slot_rec_t                rec,
    input  logic [vsa_pkg::PRIO_W-1:0]        best_prio,
    input  logic [vsa_pkg::TIME_W-1:0]        best_time,
    input  logic [vsa_pkg::ENT_W-1:0]         req_entity,
    input  logic [vsa_pkg::CHAN_W-1:0]        req_channel,
    output vsa_pkg::cmp_res_t                 res
);

    logic prio_lt;
    logic prio_eq;
    logic time_lt;

    assign prio_lt = rec.data.prio < best_prio;
    assign prio_eq = rec.data.prio == best_prio;
    assign time_lt = rec.data.last_use < best_time;

    // one slot against the running weakest and the request owner
    always_comb begin
        res.is_empty  = !rec.locked && !rec.active;
        res.is_weaker = !rec.locked && (prio_lt || (prio_eq && time_lt));
        res.is_match  = !rec.locked && (rec.data.entity == req_entity)
                        && (rec.data.channel == req_channel) && (req_channel != '0);
    end

endmodule

[rtl/core/voice_slot_allocator.sv]
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | tuser: command; tdata: slot_index, priority, entity,
//         |     |                   |        channel, now_ms
// m_      | out | m_tvalid/m_tready | tdata: granted, granted_slot; tuser: grant_kind
// cfg_    | in  | cfg_wr_en         | slots_in_use
//
// allocate walks the live slots one per cycle through the compare unit, and an owner
// match ends the walk early. stop all sweeps the slot store one slot per cycle.
// one item at a time; s_tready is low while busy.
// aresetn clears the slot flags and the control state; the result register frees the
// block as soon as it is loaded, so a stalled m_ side holds only the following item.
module voice_slot_allocator #(
    parameter int NUM_SLOTS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // slot_index[6:0], request_priority[10:7],
                                   // owner_entity[21:11], owner_channel[30:22], now_ms[62:31]
    input  logic [2:0]  s_tuser,   // command[2:0]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // granted[0], granted_slot[7:1]
    output logic [1:0]  m_tuser,   // grant_kind[1:0]
    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

    // input fields
    logic [vsa_pkg::CMD_W-1:0]  in_cmd;
    logic [vsa_pkg::IDX_W-1:0]  in_idx;
    logic [vsa_pkg::PRIO_W-1:0] in_prio;
    logic [vsa_pkg::ENT_W-1:0]  in_ent;
    logic [vsa_pkg::CHAN_W-1:0] in_chan;
    logic [vsa_pkg::TIME_W-1:0] in_now;

    assign in_cmd  = s_tuser;
    assign in_idx  = s_tdata[6:0];
    assign in_prio = s_tdata[10:7];
    assign in_ent  = s_tdata[21:11];
    assign in_chan = s_tdata[30:22];
    assign in_now  = s_tdata[62:31];

    vsa_pkg::state_t state_reg, state_next;
    logic [vsa_pkg::CFG_W-1:0] cfg_reg;
    logic m_valid_reg, m_valid_next;

    logic [vsa_pkg::IDX_W-1:0]  req_idx_reg, req_idx_next;
    logic [vsa_pkg::PRIO_W-1:0] req_prio_reg, req_prio_next;
    logic [vsa_pkg::ENT_W-1:0]  req_ent_reg, req_ent_next;
    logic [vsa_pkg::CHAN_W-1:0] req_chan_reg, req_chan_next;
    logic [vsa_pkg::TIME_W-1:0] req_now_reg, req_now_next;

    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              have_empty_reg, have_empty_next;
    logic [SLOT_W-1:0] empty_reg, empty_next;
    logic              have_weak_reg, have_weak_next;
    logic [SLOT_W-1:0] weak_reg, weak_next;
    logic [vsa_pkg::PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [vsa_pkg::TIME_W-1:0] best_time_reg, best_time_next;

    logic                        res_granted_reg, res_granted_next;
    logic [vsa_pkg::IDX_W-1:0]   res_slot_reg, res_slot_next;
    logic [vsa_pkg::KIND_W-1:0]  res_kind_reg, res_kind_next;
    logic                        m_granted_reg, m_granted_next;
    logic [vsa_pkg::IDX_W-1:0]   m_slot_reg, m_slot_next;
    logic [vsa_pkg::KIND_W-1:0]  m_kind_reg, m_kind_next;

    // store and compare unit hookup
    logic [SLOT_W-1:0]   rd_addr;
    logic [SLOT_W-1:0]   wr_addr;
    vsa_pkg::store_op_t  op;
    vsa_pkg::slot_data_t wr_data;
    vsa_pkg::slot_rec_t  rd_rec;
    vsa_pkg::cmp_res_t   cr;

    // live slot count, clamped to the table size
    logic [CNT_W-1:0] n_live;
    logic             last_entry;
    logic             in_idx_ok;
    logic             req_idx_ok;

    assign n_live     = (32'(cfg_reg) > NUM_SLOTS) ? CNT_W'(NUM_SLOTS) : CNT_W'(cfg_reg);
    assign last_entry = (32'(cnt_reg) + 32'd1) == 32'(n_live);
    assign in_idx_ok  = 32'(in_idx) < 32'(n_live);
    assign req_idx_ok = 32'(req_idx_reg) < 32'(n_live);

    vsa_slot_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .op      (op),
        .wr_data (wr_data),
        .rd_rec  (rd_rec)
    );

    vsa_cmp_unit u_cmp (
        .rec         (rd_rec),
        .best_prio   (best_prio_reg),
        .best_time   (best_time_reg),
        .req_entity  (req_ent_reg),
        .req_channel (req_chan_reg),
        .res         (cr)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vsa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            cfg_reg     <= vsa_pkg::CFG_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    // request, scan and result registers
    always_ff @(posedge aclk) begin
        req_idx_reg     <= req_idx_next;
        req_prio_reg    <= req_prio_next;
        req_ent_reg     <= req_ent_next;
        req_chan_reg    <= req_chan_next;
        req_now_reg     <= req_now_next;
        cnt_reg         <= cnt_next;
        have_empty_reg  <= have_empty_next;
        empty_reg       <= empty_next;
        have_weak_reg   <= have_weak_next;
        weak_reg        <= weak_next;
        best_prio_reg   <= best_prio_next;
        best_time_reg   <= best_time_next;
        res_granted_reg <= res_granted_next;
        res_slot_reg    <= res_slot_next;
        res_kind_reg    <= res_kind_next;
        m_granted_reg   <= m_granted_next;
        m_slot_reg      <= m_slot_next;
        m_kind_reg      <= m_kind_next;
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        req_idx_next     = req_idx_reg;
        req_prio_next    = req_prio_reg;
        req_ent_next     = req_ent_reg;
        req_chan_next    = req_chan_reg;
        req_now_next     = req_now_reg;
        cnt_next         = cnt_reg;
        have_empty_next  = have_empty_reg;
        empty_next       = empty_reg;
        have_weak_next   = have_weak_reg;
        weak_next        = weak_reg;
        best_prio_next   = best_prio_reg;
        best_time_next   = best_time_reg;
        res_granted_next = res_granted_reg;
        res_slot_next    = res_slot_reg;
        res_kind_next    = res_kind_reg;
        m_granted_next   = m_granted_reg;
        m_slot_next      = m_slot_reg;
        m_kind_next      = m_kind_reg;
        s_tready         = 1'b0;
        rd_addr          = cnt_reg + SLOT_W'(1);
        wr_addr          = cnt_reg;
        op               = '0;
        wr_data          = '{prio: req_prio_reg, last_use: req_now_reg,
                             entity: req_ent_reg, channel: req_chan_reg};

        case (state_reg)
            vsa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                // first read goes out with the beat
                rd_addr  = (in_cmd == vsa_pkg::CMD_RELEASE) ? SLOT_W'(in_idx) : '0;
                if (s_tvalid) begin
                    req_idx_next     = in_idx;
                    req_prio_next    = in_prio;
                    req_ent_next     = in_ent;
                    req_chan_next    = in_chan;
                    req_now_next     = in_now;
                    cnt_next         = '0;
                    have_empty_next  = 1'b0;
                    have_weak_next   = 1'b0;
                    best_prio_next   = in_prio;
                    best_time_next   = in_now;
                    res_granted_next = 1'b0;
                    res_slot_next    = '0;
                    res_kind_next    = vsa_pkg::KIND_NONE;
                    case (in_cmd)
                        vsa_pkg::CMD_ALLOC: begin
                            state_next = (n_live == '0) ? vsa_pkg::ST_DONE
                                                        : vsa_pkg::ST_SCAN;
                        end
                        vsa_pkg::CMD_LOCK, vsa_pkg::CMD_UNLOCK: begin
                            if (in_idx_ok) begin
                                op.lk_en         = 1'b1;
                                op.lk_val        = (in_cmd == vsa_pkg::CMD_LOCK);
                                wr_addr          = SLOT_W'(in_idx);
                                res_granted_next = 1'b1;
                            end
                            state_next = vsa_pkg::ST_DONE;
                        end
                        vsa_pkg::CMD_RELEASE: begin
                            state_next = vsa_pkg::ST_RELEASE;
                        end
                        vsa_pkg::CMD_STOP_ALL: begin
                            res_granted_next = 1'b1;
                            state_next = (n_live == '0) ? vsa_pkg::ST_DONE
                                                        : vsa_pkg::ST_SWEEP;
                        end
                        default: begin
                            state_next = vsa_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            vsa_pkg::ST_SCAN: begin
                // fold one slot into the running picks
                if (cr.is_empty && !have_empty_reg) begin
                    have_empty_next = 1'b1;
                    empty_next      = cnt_reg;
                end
                if (cr.is_weaker) begin
                    have_weak_next = 1'b1;
                    weak_next      = cnt_reg;
                    best_prio_next = rd_rec.data.prio;
                    best_time_next = rd_rec.data.last_use;
                end
                if (cr.is_match) begin
                    op.wr_en         = 1'b1;
                    wr_addr          = cnt_reg;
                    res_granted_next = 1'b1;
                    res_slot_next    = vsa_pkg::IDX_W'(cnt_reg);
                    res_kind_next    = vsa_pkg::KIND_MATCH;
                    state_next       = vsa_pkg::ST_DONE;
                end else if (last_entry) begin
                    // end of table: empty slot first, then the weakest
                    if (have_empty_next) begin
                        op.wr_en         = 1'b1;
                        wr_addr          = empty_next;
                        res_granted_next = 1'b1;
                        res_slot_next    = vsa_pkg::IDX_W'(empty_next);
                        res_kind_next    = vsa_pkg::KIND_EMPTY;
                    end else if (have_weak_next) begin
                        op.wr_en         = 1'b1;
                        wr_addr          = weak_next;
                        res_granted_next = 1'b1;
                        res_slot_next    = vsa_pkg::IDX_W'(weak_next);
                        res_kind_next    = vsa_pkg::KIND_STEAL;
                    end
                    state_next = vsa_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg + SLOT_W'(1);
                end
            end

            vsa_pkg::ST_RELEASE: begin
                if (req_idx_ok && !rd_rec.locked) begin
                    op.kill_en       = 1'b1;
                    wr_addr          = SLOT_W'(req_idx_reg);
                    res_granted_next = 1'b1;
                end
                state_next = vsa_pkg::ST_DONE;
            end

            vsa_pkg::ST_SWEEP: begin
                // kill one slot per cycle; the store skips locked ones
                op.kill_en = 1'b1;
                wr_addr    = cnt_reg;
                if (last_entry) begin
                    state_next = vsa_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg + SLOT_W'(1);
                end
            end

            vsa_pkg::ST_DONE: begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_slot_next    = res_slot_reg;
                    m_kind_next    = res_kind_reg;
                    state_next     = vsa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = vsa_pkg::ST_IDLE;
            end
        endcase
    end

    // result beat
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_slot_reg, m_granted_reg};
    assign m_tuser  = m_kind_reg;

endmodule

[rtl/core/vsa_checker.sv]
module vsa_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // any real grant kind comes with granted set
    a_kind_granted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != vsa_pkg::KIND_NONE) |-> m_tdata[0])
        else $error("grant kind without grant");

    // no slot number without an allocate grant
    a_none_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == vsa_pkg::KIND_NONE) |-> (m_tdata[7:1] == 7'd0))
        else $error("slot number on a non-allocate result");

    // the block is busy in the cycle after it takes a beat
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after a taken beat");

endmodule

bind voice_slot_allocator vsa_checker u_vsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[dv/voice_slot_allocator_tb.sv]
module voice_slot_allocator_tb;

    localparam int NUM_SLOTS  = 128;
    localparam int IDLE_LIMIT = 2000;   // cycles with no beat on either side
    localparam int SETTLE     = 300;    // quiet cycles after the last grant

    // first command code with no meaning, and the last one
    localparam logic [vsa_pkg::CMD_W-1:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [vsa_pkg::CMD_W-1:0]  CMD_MAX       = 3'd7;
    localparam logic [vsa_pkg::ENT_W-1:0]  ENT_NONE      = '1;
    localparam logic [vsa_pkg::CHAN_W-1:0] CHAN_NONE     = '1;
    localparam logic [vsa_pkg::IDX_W-1:0]  IDX_MAX       = '1;
    localparam logic [vsa_pkg::TIME_W-1:0] TIME_MAX      = '1;

    typedef struct packed {
        logic                       granted;
        logic [vsa_pkg::IDX_W-1:0]  slot;
        logic [vsa_pkg::KIND_W-1:0] kind;
    } grant_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;
    logic [2:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    // predicted voice table
    logic                       voice_active [NUM_SLOTS];
    logic                       voice_locked [NUM_SLOTS];
    logic [vsa_pkg::PRIO_W-1:0] voice_prio   [NUM_SLOTS];
    logic [vsa_pkg::TIME_W-1:0] voice_used   [NUM_SLOTS];
    logic [vsa_pkg::ENT_W-1:0]  voice_entity [NUM_SLOTS];
    logic [vsa_pkg::CHAN_W-1:0] voice_chan   [NUM_SLOTS];
    logic [vsa_pkg::CFG_W-1:0]  slot_count_cfg;

    grant_t expected_grants[$];

    int          errors         = 0;
    int          requests_sent  = 0;
    int          grants_checked = 0;
    int          kind_seen[4]   = '{0, 0, 0, 0};
    int          burst_left     = 0;
    bit          sender_eager   = 1'b0;
    logic [31:0] clock_ms       = '0;
    logic [15:0] rdy_pattern    = '1;
    logic [3:0]  rdy_phase      = '0;
    int          idle_cycles    = 0;

    voice_slot_allocator #(
        .NUM_SLOTS(NUM_SLOTS)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int live_slots();
        return (slot_count_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(slot_count_cfg);
    endfunction

    function automatic void clear_voice_table();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            voice_active[i] = 1'b0;
            voice_locked[i] = 1'b0;
            voice_prio[i]   = '0;
            voice_used[i]   = '0;
            voice_entity[i] = '0;
            voice_chan[i]   = '0;
        end
        slot_count_cfg = vsa_pkg::CFG_RESET;
    endfunction

    // a locked voice survives a kill
    function automatic void kill_voice(input int i);
        if (!voice_locked[i]) begin
            voice_active[i] = 1'b0;
            voice_prio[i]   = '0;
            voice_used[i]   = '0;
            voice_entity[i] = ENT_NONE;
            voice_chan[i]   = CHAN_NONE;
        end
    endfunction

    function automatic grant_t predict_grant(input logic [vsa_pkg::CMD_W-1:0] cmd,
                                             input logic [vsa_pkg::IDX_W-1:0] idx,
                                             input logic [vsa_pkg::PRIO_W-1:0] prio,
                                             input logic [vsa_pkg::ENT_W-1:0] ent,
                                             input logic [vsa_pkg::CHAN_W-1:0] chan,
                                             input logic [vsa_pkg::TIME_W-1:0] now);
        grant_t                     g;
        int                         n;
        bit                         found_empty;
        bit                         found_weak;
        bit                         found_match;
        int                         empty_at;
        int                         weak_at;
        int                         match_at;
        int                         pick;
        logic [vsa_pkg::PRIO_W-1:0] w_prio;
        logic [vsa_pkg::TIME_W-1:0] w_used;
        n           = live_slots();
        g           = '{granted: 1'b0, slot: '0, kind: vsa_pkg::KIND_NONE};
        found_empty = 1'b0;
        found_weak  = 1'b0;
        found_match = 1'b0;
        empty_at    = 0;
        weak_at     = 0;
        match_at    = 0;
        pick        = 0;
        w_prio      = prio;
        w_used      = now;
        case (cmd)
            vsa_pkg::CMD_ALLOC: begin
                // scan: first empty, weakest so far, stop on an owner match
                for (int i = 0; i < n; i++) begin
                    if (voice_locked[i]) continue;
                    if (!voice_active[i] && !found_empty) begin
                        found_empty = 1'b1;
                        empty_at    = i;
                    end
                    if (voice_prio[i] < w_prio ||
                        (voice_prio[i] == w_prio && voice_used[i] < w_used)) begin
                        w_prio     = voice_prio[i];
                        w_used     = voice_used[i];
                        weak_at    = i;
                        found_weak = 1'b1;
                    end
                    if (voice_entity[i] == ent && voice_chan[i] == chan && chan != '0) begin
                        found_match = 1'b1;
                        match_at    = i;
                        break;
                    end
                end
                if (found_match) begin
                    pick   = match_at;
                    g.kind = vsa_pkg::KIND_MATCH;
                end else if (found_empty) begin
                    pick   = empty_at;
                    g.kind = vsa_pkg::KIND_EMPTY;
                end else if (found_weak) begin
                    pick   = weak_at;
                    g.kind = vsa_pkg::KIND_STEAL;
                end
                if (g.kind != vsa_pkg::KIND_NONE) begin
                    kill_voice(pick);
                    voice_used[pick]   = now;
                    voice_prio[pick]   = prio;
                    voice_entity[pick] = ent;
                    voice_chan[pick]   = chan;
                    voice_active[pick] = 1'b1;
                    voice_locked[pick] = 1'b0;
                    g.granted          = 1'b1;
                    g.slot             = pick[vsa_pkg::IDX_W-1:0];
                end
            end
            vsa_pkg::CMD_LOCK, vsa_pkg::CMD_UNLOCK: begin
                if (int'(idx) < n) begin
                    voice_locked[idx] = (cmd == vsa_pkg::CMD_LOCK);
                    g.granted         = 1'b1;
                end
            end
            vsa_pkg::CMD_RELEASE: begin
                if (int'(idx) < n && !voice_locked[idx]) begin
                    kill_voice(int'(idx));
                    g.granted = 1'b1;
                end
            end
            vsa_pkg::CMD_STOP_ALL: begin
                for (int i = 0; i < n; i++) kill_voice(i);
                g.granted = 1'b1;
            end
            default: begin
            end
        endcase
        return g;
    endfunction

    // ---------------------------------------------------------------- sender

    // bursts of back-to-back beats with random gaps between them
    task automatic send_request(input logic [vsa_pkg::CMD_W-1:0] cmd,
                                input logic [vsa_pkg::IDX_W-1:0] idx,
                                input logic [vsa_pkg::PRIO_W-1:0] prio,
                                input logic [vsa_pkg::ENT_W-1:0] ent,
                                input logic [vsa_pkg::CHAN_W-1:0] chan,
                                input logic [vsa_pkg::TIME_W-1:0] now);
        int     gap;
        grant_t g;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if (!sender_eager && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, now, chan, ent, prio, idx};
        do @(posedge aclk); while (!s_tready);
        g = predict_grant(cmd, idx, prio, ent, chan, now);
        expected_grants.push_back(g);
        requests_sent++;
        kind_seen[g.kind]++;
        burst_left--;
    endtask

    task automatic alloc_voice(input logic [vsa_pkg::PRIO_W-1:0] prio,
                               input logic [vsa_pkg::ENT_W-1:0] ent,
                               input logic [vsa_pkg::CHAN_W-1:0] chan,
                               input logic [vsa_pkg::TIME_W-1:0] now);
        send_request(vsa_pkg::CMD_ALLOC, vsa_pkg::IDX_W'($urandom), prio, ent, chan, now);
    endtask

    task automatic slot_command(input logic [vsa_pkg::CMD_W-1:0] cmd,
                                input logic [vsa_pkg::IDX_W-1:0] idx);
        send_request(cmd, idx, vsa_pkg::PRIO_W'($urandom), vsa_pkg::ENT_W'($urandom),
                     vsa_pkg::CHAN_W'($urandom), $urandom);
    endtask

    // drop valid and hold off until every grant has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_grants.size() > 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_slots(input logic [vsa_pkg::CFG_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        slot_count_cfg  = value;
        burst_left      = 0;
    endtask

    // mostly allocations over a small owner pool so matches and steals happen
    task automatic send_random_request();
        int                         r;
        int                         n;
        logic [vsa_pkg::CMD_W-1:0]  cmd;
        logic [vsa_pkg::IDX_W-1:0]  idx;
        logic [vsa_pkg::ENT_W-1:0]  ent;
        logic [vsa_pkg::CHAN_W-1:0] chan;
        n = live_slots();
        r = $urandom_range(0, 99);
        if (r < 60)      cmd = vsa_pkg::CMD_ALLOC;
        else if (r < 69) cmd = vsa_pkg::CMD_LOCK;
        else if (r < 79) cmd = vsa_pkg::CMD_UNLOCK;
        else if (r < 92) cmd = vsa_pkg::CMD_RELEASE;
        else if (r < 96) cmd = vsa_pkg::CMD_STOP_ALL;
        else             cmd = vsa_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_MAX));
        if (n > 0 && $urandom_range(0, 4) != 0) idx = vsa_pkg::IDX_W'($urandom_range(0, n - 1));
        else                                    idx = vsa_pkg::IDX_W'($urandom);
        r = $urandom_range(0, 9);
        if (r < 6)       ent = vsa_pkg::ENT_W'($urandom_range(0, 5));
        else if (r == 6) ent = ENT_NONE;
        else if (r == 7) ent = 11'd1023;
        else             ent = vsa_pkg::ENT_W'($urandom_range(0, 1023));
        r = $urandom_range(0, 9);
        if (r < 4)       chan = vsa_pkg::CHAN_W'($urandom_range(1, 3));
        else if (r == 4) chan = '0;
        else if (r == 5) chan = CHAN_NONE;
        else if (r == 6) chan = 9'd255;
        else             chan = vsa_pkg::CHAN_W'($urandom_range(0, 255));
        // time mostly moves forward, with jumps anywhere and near the top
        r = $urandom_range(0, 49);
        if (r < 2)       clock_ms = $urandom;
        else if (r == 2) clock_ms = TIME_MAX - $urandom_range(0, 100);
        else             clock_ms = clock_ms + $urandom_range(0, 40);
        send_request(cmd, idx, vsa_pkg::PRIO_W'($urandom_range(0, 15)), ent, chan, clock_ms);
    endtask

    // ---------------------------------------------------------------- receiver

    // stall pattern of its own, sometimes a run with no stalls at all
    always @(posedge aclk) begin
        if (rdy_phase == 0) begin
            if ($urandom_range(0, 3) == 0) rdy_pattern = '1;
            else                           rdy_pattern = 16'($urandom) | 16'h0001;
        end
        m_tready  <= rdy_pattern[rdy_phase];
        rdy_phase  = rdy_phase + 1'b1;
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // compare each grant beat with the oldest prediction
    always @(posedge aclk) begin : grant_check
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected grant beat: expected none, actual tdata %0h tuser %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = expected_grants.pop_front();
                check_field("granted", 32'(want.granted), 32'(m_tdata[0]));
                check_field("granted_slot", 32'(want.slot), 32'(m_tdata[7:1]));
                check_field("grant_kind", 32'(want.kind), 32'(m_tuser));
                grants_checked++;
            end
        end
    end

    // watchdog on beats from either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else                                                  idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d grants outstanding",
                     $time, IDLE_LIMIT, expected_grants.size());
            $display("voice_slot_allocator_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // match, empty, steal and fail paths on a four-slot table
    task automatic test_alloc_rules();
        write_slots(8'd4);
        alloc_voice(4'd3, 11'd0, 9'd1, 32'd10);
        alloc_voice(4'd3, 11'd0, 9'd1, 32'd20);
        alloc_voice(4'd15, ENT_NONE, CHAN_NONE, TIME_MAX);
        alloc_voice(4'd7, 11'd1023, 9'd255, 32'd30);
        alloc_voice(4'd2, 11'd5, 9'd0, 32'd40);
        // channel zero never matches, table full: steal the older equal priority
        alloc_voice(4'd2, 11'd5, 9'd0, 32'd50);
        // nothing weaker than priority 0 at time 0
        alloc_voice(4'd0, 11'd6, 9'd2, 32'd0);
        // owner none on channel none is still a match
        alloc_voice(4'd15, ENT_NONE, CHAN_NONE, 32'd5);
    endtask

    // lock, unlock, release, stop all and unused codes, in and out of range
    task automatic test_slot_commands();
        slot_command(vsa_pkg::CMD_LOCK, 7'd0);
        alloc_voice(4'd3, 11'd0, 9'd1, 32'd60);
        slot_command(vsa_pkg::CMD_LOCK, IDX_MAX);
        slot_command(vsa_pkg::CMD_RELEASE, 7'd0);
        slot_command(vsa_pkg::CMD_RELEASE, 7'd2);
        slot_command(vsa_pkg::CMD_RELEASE, IDX_MAX);
        slot_command(vsa_pkg::CMD_STOP_ALL, 7'd0);
        slot_command(vsa_pkg::CMD_UNLOCK, 7'd0);
        slot_command(vsa_pkg::CMD_UNLOCK, 7'd64);
        slot_command(CMD_UNUSED_LO, 7'd0);
        slot_command(CMD_MAX, 7'd0);
        slot_command(vsa_pkg::CMD_RELEASE, 7'd0);
        alloc_voice(4'd9, 11'd3, 9'd3, 32'd70);
    endtask

    // no slots, more slots than exist, and a single slot
    task automatic test_slot_count_limits();
        write_slots(8'd0);
        alloc_voice(4'd15, 11'd1, 9'd1, 32'd80);
        slot_command(vsa_pkg::CMD_LOCK, 7'd0);
        write_slots(8'd255);
        alloc_voice(4'd1, 11'd2, 9'd2, 32'd90);
        slot_command(vsa_pkg::CMD_RELEASE, IDX_MAX);
        write_slots(8'd1);
        slot_command(vsa_pkg::CMD_LOCK, 7'd0);
        alloc_voice(4'd15, 11'd4, 9'd4, 32'd100);
    endtask

    // random traffic over seven small tables and one of random size, one pause for a full drain
    task automatic test_random_traffic();
        logic [vsa_pkg::CFG_W-1:0] sizes[8];
        sizes = '{8'd2, 8'd3, 8'd5, 8'd1, 8'd8, 8'd16, 8'd4, 8'd0};
        sizes[7] = vsa_pkg::CFG_W'($urandom_range(1, 128));
        foreach (sizes[p]) begin
            write_slots(sizes[p]);
            sender_eager = (p == 4);
            for (int k = 0; k < 40; k++) begin
                if (p == 2 && k == 20) wait_drained();
                send_random_request();
            end
        end
        sender_eager = 1'b0;
    endtask

    // full-size table, then one slot short of it
    task automatic test_full_table();
        write_slots(8'd128);
        for (int k = 0; k < 60; k++) send_random_request();
        write_slots(8'd127);
        for (int k = 0; k < 20; k++) send_random_request();
    endtask

    initial begin
        clear_voice_table();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_alloc_rules();
        test_slot_commands();
        test_slot_count_limits();
        test_random_traffic();
        test_full_table();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        $display("ran %0d requests, checked %0d grants over table sizes 0 to 255",
                 requests_sent, grants_checked);
        $display("grant kinds: %0d owner match, %0d empty, %0d stolen, %0d none",
                 kind_seen[vsa_pkg::KIND_MATCH], kind_seen[vsa_pkg::KIND_EMPTY],
                 kind_seen[vsa_pkg::KIND_STEAL], kind_seen[vsa_pkg::KIND_NONE]);
        if (errors == 0 && expected_grants.size() == 0) begin
            $display("voice_slot_allocator_tb: PASS");
        end else begin
            $display("voice_slot_allocator_tb: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/vsa_pkg.sv
rtl/core/vsa_slot_store.sv
rtl/core/vsa_cmp_unit.sv
rtl/core/voice_slot_allocator.sv
rtl/core/vsa_checker.sv
dv/voice_slot_allocator_tb.sv
